### rtl/ctb_pkg.sv
// Shared types and constants for the callout timer bank.
// Holds the request and result beat layouts and the request codes.
// No dependencies.
`default_nettype none

package ctb_pkg;

	// Widths fixed by the request and result layouts.
	localparam int COUNT_W     = 24;
	localparam int SLOT_W      = 4;
	localparam int TYPE_W      = 3;

	// Default sizing of the bank.
	localparam int SLOTS_DEF   = 16;
	localparam int STEP_DEF    = 1;

	// Upper bound on firings reported by a single tick.
	localparam int MAX_RESULTS = 16;

	// Request codes.
	localparam logic [TYPE_W-1:0] REQ_ARM   = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_STOP  = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_QUERY = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_TICK  = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_INIT  = 3'd4;

	typedef struct packed {
		logic [TYPE_W-1:0]  req_type;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] result_slot;
		logic              pending;
		logic              fired;
		logic              last;
	} res_t;

endpackage

`default_nettype wire

### rtl/ctb_ram.sv
// Simple dual-port synchronous RAM for the callout timer bank.
// One write port, one read port with registered read data. No dependencies.
`default_nettype none

module ctb_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/callout_timer_bank.sv
// Arm and init take effect at the accepting edge and keep busy low.
// Stop and query hold busy in ST_OP; its answer beat is registered and strobes after it.
// A tick holds busy in ST_SCAN and ST_FLUSH: one slot per cycle through the count and
// armed memories, firing beats stream during the sweep and the final one follows it.
// Reset clears every listed bit at once; no clearing pass is needed.
// Depends on ctb_pkg and ctb_ram.
`default_nettype none

module callout_timer_bank import ctb_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	parameter int STEP  = STEP_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      strobe,
	output res_t      result
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NUM_W = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_OP    = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]         state_q;
	logic [SLOTS-1:0]   listed_q;
	logic               res_valid_q;
	res_t               result_q;

	// Request decode.
	logic               accept;
	logic [IDX_W+3:0]   slot_wide;
	logic [IDX_W-1:0]   req_idx;
	logic               req_in_range;

	// Held stop or query.
	logic               op_stop_q;
	logic               op_valid_q;
	logic [IDX_W-1:0]   op_idx_q;
	logic [SLOT_W-1:0]  op_slot_q;

	// Tick sweep.
	logic [IDX_W-1:0]   scan_idx_q;
	logic [IDX_W:0]     scan_next;
	logic [IDX_W+3:0]   scan_wide;
	logic [SLOT_W-1:0]  scan_slot;
	logic               scan_end;
	logic [NUM_W-1:0]   fire_n_q;
	logic               hold_valid_q;
	logic [SLOT_W-1:0]  hold_slot_q;
	logic               cur_listed;
	logic               fire_now;
	logic [COUNT_W:0]   cnt_ext;
	logic [COUNT_W:0]   step_ext;
	logic [COUNT_W:0]   cnt_diff;
	logic [COUNT_W-1:0] new_cnt;

	// Memory ports.
	logic [IDX_W-1:0]   rd_addr;
	logic               cnt_we;
	logic [IDX_W-1:0]   cnt_waddr;
	logic [COUNT_W-1:0] cnt_wdata;
	logic [COUNT_W-1:0] cnt_rdata;
	logic               arm_we;
	logic [0:0]         arm_wdata;
	logic [0:0]         arm_rdata;

	// Result beat staged for the output register.
	logic               emit;
	res_t               emit_res;
	logic               op_pending;

	assign busy   = (state_q != ST_IDLE);
	assign strobe = res_valid_q;
	assign result = result_q;
	assign accept = start && !busy;

	// Map the request slot onto a memory index and check it against the bank size.
	assign slot_wide    = {{IDX_W{1'b0}}, req.slot};
	assign req_idx      = slot_wide[IDX_W-1:0];
	assign req_in_range = (slot_wide < (IDX_W + 4)'(SLOTS));

	// Sweep position and the slot number it reports.
	assign scan_next = {1'b0, scan_idx_q} + (IDX_W + 1)'(1);
	assign scan_wide = {4'b0000, scan_idx_q};
	assign scan_slot = scan_wide[SLOT_W-1:0];
	assign scan_end  = (scan_idx_q == IDX_W'(SLOTS - 1));

	// Countdown update for the slot whose data has just been read.
	assign cur_listed = listed_q[scan_idx_q];
	assign cnt_ext    = {1'b0, cnt_rdata};
	assign step_ext   = (COUNT_W + 1)'(STEP);
	assign cnt_diff   = cnt_ext - step_ext;

	always_comb begin
		if (cnt_rdata == COUNT_W'(1)) begin
			new_cnt = '0;
		end else if (cnt_ext <= step_ext) begin
			new_cnt = COUNT_W'(1);
		end else begin
			new_cnt = cnt_diff[COUNT_W-1:0];
		end
	end

	assign fire_now = (state_q == ST_SCAN) && cur_listed && (cnt_rdata == COUNT_W'(1))
		&& arm_rdata[0] && (fire_n_q < NUM_W'(MAX_RESULTS));

	// Read address: the sweep reads one slot ahead, a tick slot 0, else the requested slot.
	always_comb begin
		if (state_q == ST_SCAN) begin
			rd_addr = scan_next[IDX_W-1:0];
		end else if (req.req_type == REQ_TICK) begin
			rd_addr = '0;
		end else begin
			rd_addr = req_idx;
		end
	end

	// Count memory writes come from arm requests and from the tick sweep.
	assign cnt_we = (accept && (req.req_type == REQ_ARM) && req_in_range)
		|| ((state_q == ST_SCAN) && cur_listed && (cnt_rdata != '0));
	assign cnt_waddr = (state_q == ST_SCAN) ? scan_idx_q : req_idx;
	assign cnt_wdata = (state_q == ST_SCAN) ? new_cnt : req.count;

	// Armed memory writes come from arm and init only; unlisting hides the bit.
	assign arm_we    = accept && req_in_range
		&& ((req.req_type == REQ_ARM) || (req.req_type == REQ_INIT));
	assign arm_wdata = (req.req_type == REQ_ARM) ? 1'b1 : 1'b0;

	ctb_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (SLOTS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (rd_addr),
		.rdata (cnt_rdata)
	);

	ctb_ram #(
		.WIDTH (1),
		.DEPTH (SLOTS)
	) u_arm_ram (
		.clk   (clk),
		.we    (arm_we),
		.waddr (req_idx),
		.wdata (arm_wdata),
		.raddr (rd_addr),
		.rdata (arm_rdata)
	);

	// Select the result beat produced in this cycle, if any.
	assign op_pending = op_valid_q && listed_q[op_idx_q] && arm_rdata[0];

	always_comb begin
		emit     = 1'b0;
		emit_res = '0;
		case (state_q)
			ST_OP: begin
				emit     = 1'b1;
				emit_res = '{result_slot: op_slot_q, pending: op_pending,
					fired: 1'b0, last: 1'b1};
			end
			ST_SCAN: begin
				emit     = fire_now && hold_valid_q;
				emit_res = '{result_slot: hold_slot_q, pending: 1'b0,
					fired: 1'b1, last: 1'b0};
			end
			ST_FLUSH: begin
				emit     = hold_valid_q;
				emit_res = '{result_slot: hold_slot_q, pending: 1'b0,
					fired: 1'b1, last: 1'b1};
			end
			default: begin
				emit     = 1'b0;
			end
		endcase
	end

	// Sequencer, listed bits and output strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			listed_q     <= '0;
			res_valid_q  <= 1'b0;
			scan_idx_q   <= '0;
			fire_n_q     <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_ARM: begin
								if (req_in_range) begin
									listed_q[req_idx] <= 1'b1;
								end
							end
							REQ_STOP, REQ_QUERY: begin
								state_q <= ST_OP;
							end
							REQ_TICK: begin
								state_q      <= ST_SCAN;
								scan_idx_q   <= '0;
								fire_n_q     <= '0;
								hold_valid_q <= 1'b0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_OP: begin
					if (op_stop_q && op_valid_q) begin
						listed_q[op_idx_q] <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (fire_now) begin
						hold_valid_q <= 1'b1;
						fire_n_q     <= fire_n_q + NUM_W'(1);
					end
					if (scan_end) begin
						state_q <= ST_FLUSH;
					end else begin
						scan_idx_q <= scan_next[IDX_W-1:0];
					end
				end
				ST_FLUSH: begin
					hold_valid_q <= 1'b0;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: held request, held firing and the result beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_stop_q  <= (req.req_type == REQ_STOP);
			op_valid_q <= req_in_range;
			op_idx_q   <= req_idx;
			op_slot_q  <= req.slot;
		end
		if (fire_now) begin
			hold_slot_q <= scan_slot;
		end
		if (emit) begin
			result_q <= emit_res;
		end
	end

endmodule

`default_nettype wire

### rtl/ctb_checker.sv
// Port-level checks for the callout timer bank, bound to the top level.
// Depends on ctb_pkg and callout_timer_bank.
`default_nettype none

module ctb_checker import ctb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire req_t req,
	input wire logic busy,
	input wire logic strobe,
	input wire res_t result
);

	// A stop or query keeps busy high, then gives an answer beat marked last and not fired.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((req.req_type == REQ_STOP) || (req.req_type == REQ_QUERY))
		|=> busy ##1 (strobe && result.last && !result.fired))
		else $error("stop or query answer beat missing or malformed");

	// Arm and init complete at once and give no beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((req.req_type == REQ_ARM) || (req.req_type == REQ_INIT))
		|=> (!busy && !strobe))
		else $error("arm or init held the bank busy or gave a beat");

	// A firing beat never reports a pending bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.fired |-> !result.pending)
		else $error("firing beat carries a pending bit");

	// Every result beat follows a busy cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat without preceding work");

endmodule

bind callout_timer_bank ctb_checker u_ctb_checker (.*);

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the callout timer bank.
// Drives request beats, predicts every answer and firing beat, and checks them in order.
// Depends on ctb_pkg and the callout_timer_bank RTL.
`default_nettype none

module testbench;
	import ctb_pkg::*;

	// Request codes the block must ignore.
	localparam logic [TYPE_W-1:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [TYPE_W-1:0] REQ_SPARE_LAST  = 3'd7;

	// Cycles with neither an accepted request nor a result before giving up.
	localparam int QUIET_LIMIT = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic strobe;
	res_t result;

	// Predicted bank contents.
	bit               m_listed [SLOTS_DEF];
	bit               m_armed  [SLOTS_DEF];
	logic [COUNT_W-1:0] m_count [SLOTS_DEF];

	// Beats the block still owes, oldest first.
	res_t due_beats[$];

	int unsigned fault_count = 0;
	int unsigned quiet_cycles = 0;
	bit allow_gaps = 1'b1;

	callout_timer_bank u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic req_t make_req(logic [TYPE_W-1:0] kind, int unsigned slot_no,
			logic [COUNT_W-1:0] cnt);
		req_t r;
		r.req_type = kind;
		r.slot     = SLOT_W'(slot_no);
		r.count    = cnt;
		return r;
	endfunction

	// Works out the beats one accepted request causes and updates the predicted bank.
	task automatic predict_request(input req_t r);
		res_t ans;
		res_t fires[$];
		bit hit;
		hit = (int'(r.slot) < SLOTS_DEF);
		ans = '0;
		case (r.req_type)
			REQ_ARM: begin
				if (hit) begin
					m_listed[r.slot] = 1'b1;
					m_armed[r.slot]  = 1'b1;
					m_count[r.slot]  = r.count;
				end
			end
			REQ_STOP: begin
				ans.result_slot = r.slot;
				ans.pending     = hit ? m_armed[r.slot] : 1'b0;
				ans.last        = 1'b1;
				if (hit) begin
					m_armed[r.slot]  = 1'b0;
					m_listed[r.slot] = 1'b0;
				end
				due_beats.push_back(ans);
			end
			REQ_QUERY: begin
				ans.result_slot = r.slot;
				ans.pending     = hit ? m_armed[r.slot] : 1'b0;
				ans.last        = 1'b1;
				due_beats.push_back(ans);
			end
			REQ_TICK: begin
				for (int i = 0; i < SLOTS_DEF; i++) begin
					if (m_listed[i]) begin
						if (m_count[i] == 24'd1) begin
							m_count[i] = '0;
							if (m_armed[i] && fires.size() < MAX_RESULTS) begin
								ans = '0;
								ans.result_slot = SLOT_W'(i);
								ans.fired = 1'b1;
								fires.push_back(ans);
							end
						end else if (m_count[i] != '0) begin
							if (m_count[i] <= COUNT_W'(STEP_DEF))
								m_count[i] = 24'd1;
							else
								m_count[i] = m_count[i] - COUNT_W'(STEP_DEF);
						end
					end
				end
				if (fires.size() > 0)
					fires[fires.size() - 1].last = 1'b1;
				foreach (fires[k])
					due_beats.push_back(fires[k]);
			end
			REQ_INIT: begin
				if (hit)
					m_armed[r.slot] = 1'b0;
			end
			default: begin
			end
		endcase
	endtask

	// Prediction runs on every accepted request beat.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			predict_request(req);
	end

	// Each result beat is compared with the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && strobe) begin
			if (due_beats.size() == 0) begin
				$error("unexpected result beat: result_slot %0d", result.result_slot);
				fault_count++;
			end else begin
				want = due_beats.pop_front();
				if (result.result_slot !== want.result_slot) begin
					$error("result_slot: expected %0d, actual %0d",
						want.result_slot, result.result_slot);
					fault_count++;
				end
				if (result.pending !== want.pending) begin
					$error("pending: expected %0d, actual %0d", want.pending, result.pending);
					fault_count++;
				end
				if (result.fired !== want.fired) begin
					$error("fired: expected %0d, actual %0d", want.fired, result.fired);
					fault_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, result.last);
					fault_count++;
				end
			end
		end
	end

	// Watchdog on a stalled handshake.
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("callout_timer_bank test failed");
			$finish;
		end
	end

	// Sends one request beat, with an occasional idle gap first; start stays high on return.
	task automatic send_beat(input req_t r);
		if (allow_gaps && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Holds the sender off until every predicted beat has arrived.
	task automatic wait_for_drain();
		start <= 1'b0;
		@(posedge clk);
		while (due_beats.size() != 0) @(posedge clk);
	endtask

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return COUNT_W'($urandom());
			default: return COUNT_W'($urandom_range(1, 6));
		endcase
	endfunction

	// Extremes of the fields, every request and the special cases of the bank.
	task automatic test_directed();
		send_beat(make_req(REQ_QUERY, 0, '0));
		send_beat(make_req(REQ_QUERY, 15, '1));
		// Stop on a slot that was never listed.
		send_beat(make_req(REQ_STOP, 7, '0));
		send_beat(make_req(REQ_ARM, 0, 24'd1));
		send_beat(make_req(REQ_ARM, 15, '1));
		send_beat(make_req(REQ_ARM, 5, '0));
		send_beat(make_req(REQ_ARM, 3, 24'd3));
		send_beat(make_req(REQ_ARM, 9, 24'd2));
		// Disarmed slot that stays listed and later runs down to zero silently.
		send_beat(make_req(REQ_INIT, 9, '1));
		send_beat(make_req(REQ_QUERY, 0, '0));
		send_beat(make_req(REQ_TICK, 0, '0));
		send_beat(make_req(REQ_TICK, 15, '1));
		// A fired slot stays armed.
		send_beat(make_req(REQ_QUERY, 0, '0));
		send_beat(make_req(REQ_QUERY, 9, '0));
		send_beat(make_req(REQ_TICK, 0, '0));
		send_beat(make_req(REQ_STOP, 15, '0));
		send_beat(make_req(REQ_STOP, 15, '1));
		// Unknown request codes are ignored.
		for (logic [TYPE_W:0] k = {1'b0, REQ_SPARE_FIRST}; k <= {1'b0, REQ_SPARE_LAST}; k++)
			send_beat(make_req(k[TYPE_W-1:0], $urandom_range(0, 15), COUNT_W'($urandom())));
		send_beat(make_req(REQ_ARM, 1, 24'd1));
		send_beat(make_req(REQ_ARM, 2, 24'd1));
		send_beat(make_req(REQ_ARM, 14, 24'd1));
		send_beat(make_req(REQ_TICK, 0, '0));
		// Armed slot with a zero count never fires.
		send_beat(make_req(REQ_QUERY, 5, '0));
	endtask

	// Every slot fires on the same tick, then each is stopped.
	task automatic test_full_bank();
		for (int i = 0; i < SLOTS_DEF; i++)
			send_beat(make_req(REQ_ARM, i, 24'd1));
		send_beat(make_req(REQ_TICK, $urandom_range(0, 15), COUNT_W'($urandom())));
		send_beat(make_req(REQ_TICK, 0, '0));
		for (int i = 0; i < SLOTS_DEF; i++)
			send_beat(make_req(REQ_STOP, i, '0));
	endtask

	// Random mix weighted towards arms with short counts and ticks, so that firings are common.
	task automatic test_random_traffic();
		req_t r;
		int unsigned roll;
		for (int i = 0; i < 110; i++) begin
			allow_gaps = !(i >= 40 && i < 80);
			if (i == 90)
				wait_for_drain();
			roll = $urandom_range(0, 99);
			r.slot  = SLOT_W'($urandom_range(0, 15));
			r.count = COUNT_W'($urandom());
			if (roll < 30) begin
				r.req_type = REQ_ARM;
				r.count    = pick_count();
			end else if (roll < 55)
				r.req_type = REQ_TICK;
			else if (roll < 67)
				r.req_type = REQ_STOP;
			else if (roll < 82)
				r.req_type = REQ_QUERY;
			else if (roll < 92)
				r.req_type = REQ_INIT;
			else
				r.req_type = TYPE_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
			send_beat(r);
		end
		allow_gaps = 1'b1;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_bank();
		test_random_traffic();
		wait_for_drain();
		repeat (SLOTS_DEF + 4) @(posedge clk);
		if (fault_count == 0 && due_beats.size() == 0) begin
			$display("callout_timer_bank test passed");
		end else begin
			if (due_beats.size() != 0)
				$error("%0d predicted beats never arrived", due_beats.size());
			$display("callout_timer_bank test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
